// ===== design/rria_pkg.sv =====
package rria_pkg;

  localparam int SLOT_W  = 10;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int BIT_W   = 5;
  localparam int WORD    = 1 << BIT_W;
  localparam int ROW_W   = SLOT_W - BIT_W;
  localparam int ROWS    = 1 << ROW_W;
  localparam int VISIT_W = $clog2(ROWS + 1);
  localparam int ID_W    = 20;
  localparam int OWN_W   = 16;
  localparam int SRV_W   = 10;
  localparam int FUNC_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_DESTROY = 2'd1,
    FN_LOOKUP  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             row0;
    logic [BIT_W-1:0] lo;
  } pick_ctl_t;

endpackage

// ===== design/rria_pick.sv =====
module rria_pick
  import rria_pkg::*;
(
  input  pick_ctl_t        ctl,
  input  logic [WORD-1:0]  busy,
  output logic             hit,
  output logic [BIT_W-1:0] idx
);

  logic [WORD-1:0] avail;

  // free slots of one row, limited to the part of the row this pass covers
  always_comb begin
    for (int i = 0; i < WORD; i++) begin
      avail[i] = !busy[i];
      if (ctl.first && (BIT_W'(i) < ctl.lo)) begin
        avail[i] = 1'b0;
      end
      if (ctl.last && (BIT_W'(i) >= ctl.lo)) begin
        avail[i] = 1'b0;
      end
      if (ctl.row0 && (i == 0)) begin
        avail[i] = 1'b0;
      end
    end
  end

  // lowest free position wins
  always_comb begin
    hit = |avail;
    idx = '0;
    for (int i = WORD - 1; i >= 0; i--) begin
      if (avail[i]) begin
        idx = BIT_W'(i);
      end
    end
  end

endmodule

// ===== design/round_robin_id_allocator.sv =====
// Round-robin identifier allocator. A request carries func (allocate, destroy
// or lookup), room_id and owner_index and gets exactly one answer of
// result_id, found_owner and status. Identifiers are {server_number, slot}
// with slot 0 never handed out; allocate searches forward from the slot
// after the last one claimed. The valid bits live in a memory of 32 rows of
// 32 bits with one read port; a priority pick unit examines one row per
// pass through the FETCH and EVAL states. Destroy and lookup fetch their
// row once and raise a registered answer from EVAL; allocate repeats the
// FETCH and EVAL pair for every further row searched, visiting the start
// row a second time when the table is full. After reset a clearing pass
// zeroes the valid bits before the first request is taken; server_number
// may be written at any time the block is idle, including during that pass.
module round_robin_id_allocator
  import rria_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [ID_W-1:0]   room_id,
  input  logic [OWN_W-1:0]  owner_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   result_id,
  output logic [OWN_W-1:0]  found_owner,
  output logic              status,
  input  logic              cfg_we,
  input  logic [SRV_W-1:0]  cfg_wdata
);

  state_t              state, state_next;
  logic [SRV_W-1:0]    server_number;
  logic [SLOT_W-1:0]   cursor, cursor_next;
  logic                cursor_we;
  logic [FUNC_W-1:0]   req_func;
  logic [ID_W-1:0]     req_id;
  logic [OWN_W-1:0]    req_owner;
  logic [ROW_W-1:0]    cur_row, cur_row_next;
  logic [VISIT_W-1:0]  visit, visit_next;
  logic [BIT_W-1:0]    start_lo;
  logic [SLOT_W-1:0]   start_slot;
  logic                accept;

  logic [WORD-1:0]     vmem [ROWS];
  logic [WORD-1:0]     vm_rd;
  logic                vm_we;
  logic [WORD-1:0]     vm_wdata;
  logic [OWN_W-1:0]    omem [SLOTS];
  logic [OWN_W-1:0]    own_rd;
  logic                om_we;

  logic                fin;
  logic [ID_W-1:0]     fin_id;
  logic [OWN_W-1:0]    fin_own;
  logic                fin_st;

  pick_ctl_t           pick_ctl;
  logic                pick_hit;
  logic [BIT_W-1:0]    pick_idx;
  logic [SLOT_W-1:0]   alloc_slot;
  logic [SLOT_W-1:0]   req_slot;
  logic [BIT_W-1:0]    req_bit;
  logic                present;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign start_slot = (cursor == SLOT_W'(SLOTS - 1)) ? SLOT_W'(1) : cursor + SLOT_W'(1);
  assign req_slot   = req_id[SLOT_W-1:0];
  assign req_bit    = req_slot[BIT_W-1:0];
  assign alloc_slot = {cur_row, pick_idx};
  assign present    = (req_id[ID_W-1:SLOT_W] == server_number) && (req_slot != '0)
                      && vm_rd[req_bit];

  assign pick_ctl.first = (visit == '0);
  assign pick_ctl.last  = (visit == VISIT_W'(ROWS));
  assign pick_ctl.row0  = (cur_row == '0);
  assign pick_ctl.lo    = start_lo;

  rria_pick u_pick (
    .ctl  (pick_ctl),
    .busy (vm_rd),
    .hit  (pick_hit),
    .idx  (pick_idx)
  );

  // valid-bit row memory
  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[cur_row] <= vm_wdata;
    end
    vm_rd <= vmem[cur_row];
  end

  // owner memory
  always_ff @(posedge clk) begin
    if (om_we) begin
      omem[alloc_slot] <= req_owner;
    end
    own_rd <= omem[req_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cur_row       <= '0;
      visit         <= '0;
      cursor        <= '0;
      server_number <= '0;
    end else begin
      state   <= state_next;
      cur_row <= cur_row_next;
      visit   <= visit_next;
      if (cursor_we) begin
        cursor <= cursor_next;
      end
      if (cfg_we) begin
        server_number <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func;
      req_id    <= room_id;
      req_owner <= owner_index;
      start_lo  <= start_slot[BIT_W-1:0];
    end
  end

  always_comb begin
    state_next   = state;
    cur_row_next = cur_row;
    visit_next   = visit;
    vm_we        = 1'b0;
    vm_wdata     = vm_rd;
    om_we        = 1'b0;
    cursor_we    = 1'b0;
    cursor_next  = alloc_slot;
    fin          = 1'b0;
    fin_id       = '0;
    fin_own      = '0;
    fin_st       = 1'b1;
    case (state)
      S_CLEAR: begin
        vm_we        = 1'b1;
        vm_wdata     = '0;
        cur_row_next = cur_row + ROW_W'(1);
        if (cur_row == ROW_W'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          visit_next = '0;
          state_next = S_FETCH;
          if (func_t'(func) == FN_ALLOC) begin
            cur_row_next = start_slot[SLOT_W-1:BIT_W];
          end else begin
            cur_row_next = room_id[SLOT_W-1:BIT_W];
          end
        end
      end
      S_FETCH: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (func_t'(req_func))
          FN_ALLOC: begin
            if (pick_hit) begin
              vm_we     = 1'b1;
              vm_wdata  = vm_rd | (WORD'(1) << pick_idx);
              om_we     = 1'b1;
              cursor_we = 1'b1;
              fin       = 1'b1;
              fin_id    = ID_W'({server_number, alloc_slot});
              fin_st    = 1'b0;
            end else if (pick_ctl.last) begin
              fin = 1'b1;
            end else begin
              visit_next   = visit + VISIT_W'(1);
              cur_row_next = cur_row + ROW_W'(1);
              state_next   = S_FETCH;
            end
          end
          FN_DESTROY: begin
            fin = 1'b1;
            if (present && (req_id[ID_W-1:SLOT_W] != '0)) begin
              vm_we    = 1'b1;
              vm_wdata = vm_rd & ~(WORD'(1) << req_bit);
              fin_st   = 1'b0;
            end
          end
          FN_LOOKUP: begin
            fin = 1'b1;
            if (present) begin
              fin_own = own_rd;
              fin_st  = 1'b0;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result_id   <= fin_id;
      found_owner <= fin_own;
      status      <= fin_st;
    end
  end

  a_id_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_id != '0) |-> (result_id[SLOT_W-1:0] != '0))
    else $error("allocated identifier names slot 0");

  a_cursor_nonzero: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(cursor) |-> (cursor != '0))
    else $error("cursor moved to slot 0");

  a_visit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (visit <= VISIT_W'(ROWS)))
    else $error("allocate search ran past its last row");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> ($past(state) == S_EVAL))
    else $error("result raised outside evaluation");

endmodule
